@@ src/nns_pkg.sv @@
// Shared types, constants and the helper function of the nearest-neighbor scaler.
package nns_pkg;

   // Default sizing of the frame store and the image dimensions.
   localparam int STORE_PIXELS_DEF = 65536;
   localparam int MAX_DIM_DEF      = 4096;
   localparam int PIXEL_BITS_DEF   = 32;

   // Fixed field widths of the ports.
   localparam int CFG_DIM_BITS   = 13;
   localparam int PIXEL_OUT_BITS = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILL_VALUE = 3'd4;

   // Request kinds.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EMIT = 1'b1;

   localparam logic [CFG_DIM_BITS-1:0] DIM_RESET = 13'd256;

   // Clamped configuration as seen by the front and the back.
   typedef struct packed {
      logic [CFG_DIM_BITS-1:0]   src_width;
      logic [CFG_DIM_BITS-1:0]   src_height;
      logic [CFG_DIM_BITS-1:0]   dst_width;
      logic [CFG_DIM_BITS-1:0]   dst_height;
      logic [PIXEL_OUT_BITS-1:0] fill_value;
   } cfg_type;

   // A dimension of zero counts as one; anything above the maximum counts as the maximum.
   function automatic logic [CFG_DIM_BITS-1:0] clamp_dim(input logic [CFG_DIM_BITS-1:0] v,
                                                         input logic [16:0] max_dim);
      logic [CFG_DIM_BITS-1:0] res;
      res = v;
      if (v == '0) begin
         res = CFG_DIM_BITS'(1);
      end else if ({4'b0000, v} > max_dim) begin
         res = max_dim[CFG_DIM_BITS-1:0];
      end
      return res;
   endfunction

endpackage

@@ src/nns_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module nns_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/nns_div.sv @@
// Restoring divider that retires one quotient bit per cycle.
module nns_div #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   rem_shift;
   logic [DEN_W+1:0] trial;
   logic             fits;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] quo_in;

   // The partial remainder stays below the divisor, so one shifted bit and one subtract suffice.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUM_W-1]};
      trial     = {1'b0, rem_shift} - {2'b00, den_ff};
      fits      = ~trial[DEN_W+1];
      rem_in    = fits ? trial[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      quo_in    = {quo_ff[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ src/nns_fifo.sv @@
// Small register queue between the request front and the execution back.
module nns_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/nns_front.sv @@
// Request front: accepts requests, tracks the load position and builds queue entries.
module nns_front #(
   parameter int STORE_PIXELS = nns_pkg::STORE_PIXELS_DEF,
   parameter int MAX_DIM      = nns_pkg::MAX_DIM_DEF,
   parameter int PIXEL_BITS   = nns_pkg::PIXEL_BITS_DEF,
   localparam int STORE_W = (PIXEL_BITS < nns_pkg::PIXEL_OUT_BITS) ?
                            PIXEL_BITS : nns_pkg::PIXEL_OUT_BITS,
   localparam int AW      = $clog2(STORE_PIXELS),
   localparam int ENT_W   = STORE_W + AW + 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  nns_pkg::cfg_type                    cfg,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [nns_pkg::PIXEL_OUT_BITS-1:0]  req_load_value,
   output logic                                ent_valid,
   input  logic                                ent_ready,
   output logic [ENT_W-1:0]                    ent_data
);

   localparam int DIM_W = ($clog2(MAX_DIM + 1) < nns_pkg::CFG_DIM_BITS) ?
                          $clog2(MAX_DIM + 1) : nns_pkg::CFG_DIM_BITS;
   localparam int POS_W = 2 * DIM_W;
   localparam int CMP_W = ((POS_W > AW) ? POS_W : AW) + 1;

   logic             ent_valid_ff;
   logic [ENT_W-1:0] ent_ff;
   logic [POS_W-1:0] pos_ff;

   logic             accept;
   logic [POS_W-1:0] sw_ext;
   logic [POS_W-1:0] sh_ext;
   logic [POS_W-1:0] frame;
   logic [POS_W:0]   pos_inc;
   logic             pos_wrap;
   logic [CMP_W-1:0] pos_cmp;
   logic             store_we;

   assign req_ready = !ent_valid_ff || ent_ready;
   assign accept    = req_valid && req_ready;
   assign ent_valid = ent_valid_ff;
   assign ent_data  = ent_ff;

   // The frame size sets where the load position wraps back to the start of the store.
   always_comb begin
      sw_ext   = POS_W'(cfg.src_width[DIM_W-1:0]);
      sh_ext   = POS_W'(cfg.src_height[DIM_W-1:0]);
      frame    = sw_ext * sh_ext;
      pos_inc  = {1'b0, pos_ff} + (POS_W + 1)'(1);
      pos_wrap = (pos_inc >= {1'b0, frame});
      pos_cmp  = CMP_W'(pos_ff);
      store_we = (pos_cmp < CMP_W'(STORE_PIXELS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         if (accept) begin
            ent_valid_ff <= 1'b1;
            if (req_kind == nns_pkg::KIND_LOAD) begin
               pos_ff <= pos_wrap ? '0 : pos_inc[POS_W-1:0];
            end
         end else if (ent_ready) begin
            ent_valid_ff <= 1'b0;
         end
      end
   end

   // Loads past the store capacity travel on with the write enable cleared.
   always_ff @(posedge clock) begin
      if (accept) begin
         if (req_kind == nns_pkg::KIND_LOAD) begin
            ent_ff <= {nns_pkg::KIND_LOAD, store_we, pos_cmp[AW-1:0],
                       req_load_value[STORE_W-1:0]};
         end else begin
            ent_ff <= {nns_pkg::KIND_EMIT, 1'b0, AW'(0), STORE_W'(0)};
         end
      end
   end

endmodule

@@ src/nns_back.sv @@
// Execution back: frame store writes, incremental coordinate mapping and pixel reads.
module nns_back #(
   parameter int STORE_PIXELS = nns_pkg::STORE_PIXELS_DEF,
   parameter int MAX_DIM      = nns_pkg::MAX_DIM_DEF,
   parameter int PIXEL_BITS   = nns_pkg::PIXEL_BITS_DEF,
   localparam int STORE_W = (PIXEL_BITS < nns_pkg::PIXEL_OUT_BITS) ?
                            PIXEL_BITS : nns_pkg::PIXEL_OUT_BITS,
   localparam int AW      = $clog2(STORE_PIXELS),
   localparam int ENT_W   = STORE_W + AW + 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  nns_pkg::cfg_type                    cfg,
   input  logic                                cfg_wr,
   input  logic                                head_valid,
   output logic                                head_pop,
   input  logic [ENT_W-1:0]                    head_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [nns_pkg::PIXEL_OUT_BITS-1:0]  rsp_out_value,
   output logic                                rsp_inside_res,
   output logic                                rsp_frame_end
);

   localparam int DIM_W = ($clog2(MAX_DIM + 1) < nns_pkg::CFG_DIM_BITS) ?
                          $clog2(MAX_DIM + 1) : nns_pkg::CFG_DIM_BITS;
   localparam int NUM_W = 2 * DIM_W + 1;
   localparam int REM_W = DIM_W + 1;
   localparam int POS_W = 2 * DIM_W;
   localparam int CMP_W = ((POS_W > AW) ? POS_W : AW) + 1;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PREP  = 6'b000010,
      S_START = 6'b000100,
      S_DIV   = 6'b001000,
      S_READ  = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   // Recompute steps: x position, x step, y position, y step.
   localparam logic [1:0] OP_X_POS  = 2'd0;
   localparam logic [1:0] OP_X_STEP = 2'd1;
   localparam logic [1:0] OP_Y_POS  = 2'd2;
   localparam logic [1:0] OP_Y_STEP = 2'd3;

   state_type        state_ff, state_in;
   logic             dirty_ff;
   logic [1:0]       op_ff;
   logic [DIM_W-1:0] dc_ff, dr_ff;
   logic [NUM_W-1:0] qx_ff, qy_ff;
   logic [REM_W-1:0] rx_ff, ry_ff;
   logic [DIM_W-1:0] sxq_ff, syq_ff;
   logic [REM_W-1:0] sxr_ff, syr_ff;
   logic [POS_W-1:0] prod_ff;
   logic [POS_W-1:0] addr_ff;
   logic             inside_ff;
   logic             last_ff;
   logic             inrange_ff;
   logic             rsp_valid_ff;
   logic [nns_pkg::PIXEL_OUT_BITS-1:0] rsp_value_ff;
   logic             rsp_inside_ff;
   logic             rsp_last_ff;

   logic [DIM_W-1:0] sw, sh, dw, dh;
   logic [REM_W-1:0] dw2, dh2;
   logic             head_kind;
   logic             head_we;
   logic [AW-1:0]    head_addr;
   logic [STORE_W-1:0] head_value;

   logic             map_fire;
   logic             out_free;
   logic             x_wrap, y_wrap;
   logic [REM_W:0]   x_rsum, y_rsum, x_rdiff, y_rdiff;
   logic             x_carry, y_carry;
   logic [REM_W-1:0] x_rnext, y_rnext;
   logic [NUM_W-1:0] x_qnext, y_qnext;
   logic             inside_now;
   logic [POS_W-1:0] iy_ext, ix_ext, sw_ext;
   logic [POS_W-1:0] addr_now;
   logic [CMP_W-1:0] addr_cmp;
   logic             inrange_now;

   logic [POS_W-1:0] mul_a, mul_b, prod;
   logic [DIM_W-1:0] div_t, div_s;
   logic [NUM_W-1:0] div_dividend;
   logic [REM_W-1:0] div_divisor;
   logic             div_start;
   logic             div_done;
   logic [NUM_W-1:0] div_quo;
   logic [REM_W-1:0] div_rem;

   logic             ram_we;
   logic             ram_re;
   logic [STORE_W-1:0] ram_rdata;

   always_comb begin
      sw = cfg.src_width[DIM_W-1:0];
      sh = cfg.src_height[DIM_W-1:0];
      dw = cfg.dst_width[DIM_W-1:0];
      dh = cfg.dst_height[DIM_W-1:0];
      dw2 = {dw, 1'b0};
      dh2 = {dh, 1'b0};
      head_value = head_data[STORE_W-1:0];
      head_addr  = head_data[STORE_W+AW-1:STORE_W];
      head_we    = head_data[STORE_W+AW];
      head_kind  = head_data[STORE_W+AW+1];
   end

   // Stepping one destination pixel adds the quotient and remainder of src/dst to the
   // running source coordinate; the remainder never reaches twice the divisor.
   always_comb begin
      x_wrap  = ({1'b0, dc_ff} + (DIM_W + 1)'(1)) >= {1'b0, dw};
      y_wrap  = ({1'b0, dr_ff} + (DIM_W + 1)'(1)) >= {1'b0, dh};
      x_rsum  = {1'b0, rx_ff} + {1'b0, sxr_ff};
      y_rsum  = {1'b0, ry_ff} + {1'b0, syr_ff};
      x_rdiff = x_rsum - {1'b0, dw2};
      y_rdiff = y_rsum - {1'b0, dh2};
      x_carry = (x_rsum >= {1'b0, dw2});
      y_carry = (y_rsum >= {1'b0, dh2});
      x_rnext = x_carry ? x_rdiff[REM_W-1:0] : x_rsum[REM_W-1:0];
      y_rnext = y_carry ? y_rdiff[REM_W-1:0] : y_rsum[REM_W-1:0];
      x_qnext = qx_ff + NUM_W'(sxq_ff) + NUM_W'(x_carry);
      y_qnext = qy_ff + NUM_W'(syq_ff) + NUM_W'(y_carry);
   end

   always_comb begin
      inside_now  = (qx_ff < NUM_W'(sw)) && (qy_ff < NUM_W'(sh));
      iy_ext      = POS_W'(qy_ff[DIM_W-1:0]);
      ix_ext      = POS_W'(qx_ff[DIM_W-1:0]);
      sw_ext      = POS_W'(sw);
      addr_now    = iy_ext * sw_ext + ix_ext;
      addr_cmp    = CMP_W'(addr_ff);
      inrange_now = (addr_cmp < CMP_W'(STORE_PIXELS));
   end

   // Operands of the recompute steps, chosen by the step counter.
   always_comb begin
      mul_a        = op_ff[1] ? POS_W'(dr_ff) : POS_W'(dc_ff);
      mul_b        = op_ff[1] ? POS_W'(sh) : POS_W'(sw);
      prod         = mul_a * mul_b;
      div_t        = op_ff[1] ? dh : dw;
      div_s        = op_ff[1] ? sh : sw;
      div_dividend = op_ff[0] ? NUM_W'(div_s) : ({prod_ff, 1'b0} + NUM_W'(div_t));
      div_divisor  = op_ff[0] ? {1'b0, div_t} : {div_t, 1'b0};
      div_start    = (state_ff == S_START);
   end

   always_comb begin
      map_fire = (state_ff == S_IDLE) && head_valid && (head_kind == nns_pkg::KIND_EMIT) &&
                 !dirty_ff;
      head_pop = (state_ff == S_IDLE) && head_valid &&
                 ((head_kind == nns_pkg::KIND_LOAD) || !dirty_ff);
      ram_we   = (state_ff == S_IDLE) && head_valid &&
                 (head_kind == nns_pkg::KIND_LOAD) && head_we;
      ram_re   = (state_ff == S_READ) && inrange_now;
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (head_valid && (head_kind == nns_pkg::KIND_EMIT)) begin
               state_in = dirty_ff ? S_PREP : S_READ;
            end
         end
         S_PREP:  state_in = S_START;
         S_START: state_in = S_DIV;
         S_DIV: begin
            if (div_done) begin
               state_in = (op_ff == OP_Y_STEP) ? S_IDLE : S_PREP;
            end
         end
         S_READ:  state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dirty_ff     <= 1'b1;
         op_ff        <= '0;
         dc_ff        <= '0;
         dr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr) begin
            dirty_ff <= 1'b1;
         end else if ((state_ff == S_DIV) && div_done && (op_ff == OP_Y_STEP)) begin
            dirty_ff <= 1'b0;
         end
         if (state_ff == S_IDLE) begin
            op_ff <= '0;
         end else if ((state_ff == S_DIV) && div_done) begin
            op_ff <= op_ff + 2'd1;
         end
         if (map_fire) begin
            if (x_wrap) begin
               dc_ff <= '0;
               dr_ff <= y_wrap ? '0 : dr_ff + DIM_W'(1);
            end else begin
               dc_ff <= dc_ff + DIM_W'(1);
            end
         end
         if ((state_ff == S_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (map_fire) begin
         inside_ff <= inside_now;
         addr_ff   <= addr_now;
         last_ff   <= x_wrap && y_wrap;
         if (x_wrap) begin
            qx_ff <= '0;
            rx_ff <= REM_W'(dw);
            if (y_wrap) begin
               qy_ff <= '0;
               ry_ff <= REM_W'(dh);
            end else begin
               qy_ff <= y_qnext;
               ry_ff <= y_rnext;
            end
         end else begin
            qx_ff <= x_qnext;
            rx_ff <= x_rnext;
         end
      end
      if (state_ff == S_PREP) begin
         prod_ff <= prod;
      end
      if ((state_ff == S_DIV) && div_done) begin
         case (op_ff)
            OP_X_POS: begin
               qx_ff <= div_quo;
               rx_ff <= div_rem;
            end
            OP_X_STEP: begin
               sxq_ff <= div_quo[DIM_W-1:0];
               sxr_ff <= {div_rem[DIM_W-1:0], 1'b0};
            end
            OP_Y_POS: begin
               qy_ff <= div_quo;
               ry_ff <= div_rem;
            end
            default: begin
               syq_ff <= div_quo[DIM_W-1:0];
               syr_ff <= {div_rem[DIM_W-1:0], 1'b0};
            end
         endcase
      end
      if (state_ff == S_READ) begin
         inrange_ff <= inrange_now;
      end
      if ((state_ff == S_OUT) && out_free) begin
         rsp_inside_ff <= inside_ff;
         rsp_last_ff   <= last_ff;
         if (!inside_ff) begin
            rsp_value_ff <= cfg.fill_value;
         end else if (inrange_ff) begin
            rsp_value_ff <= nns_pkg::PIXEL_OUT_BITS'(ram_rdata);
         end else begin
            rsp_value_ff <= '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_value  = rsp_value_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_frame_end  = rsp_last_ff;

   nns_div #(
      .NUM_W(NUM_W),
      .DEN_W(REM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   nns_ram #(
      .WIDTH(STORE_W),
      .DEPTH(STORE_PIXELS)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(head_addr),
      .wr_data(head_value),
      .rd_en  (ram_re),
      .rd_addr(addr_cmp[AW-1:0]),
      .rd_data(ram_rdata)
   );

`ifndef SYNTHESIS
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !dirty_ff) |-> (rx_ff < dw2 && ry_ff < dh2))
      else $error("mapping remainder reached twice the destination size");

   a_frame_end_wraps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && last_ff) |-> (dc_ff == '0 && dr_ff == '0))
      else $error("frame end flagged without the destination position wrapping");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside of a recompute step");

   a_clean_after_steps: assert property (@(posedge clock) disable iff (reset)
      $fell(dirty_ff) |-> ($past(state_ff) == S_DIV && $past(op_ff) == OP_Y_STEP))
      else $error("mapping marked valid before all recompute steps ran");
`endif

endmodule

@@ src/nearest_neighbor_image_scaler_unit.sv @@
// Top level of the nearest-neighbor image scaler: configuration registers and block wiring.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   req_kind, req_load_value
//   rsp_      out        rsp_valid/rsp_ready   rsp_out_value, rsp_inside_res, rsp_frame_end
//   csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
// A load request is written to the frame store while the back is idle; an emit request runs the
// map, store read and output steps in turn, as the address multiply and the frame store read are
// registered. After reset and after any configuration write, the first emit first runs four
// divisions on the shared bit-serial divider.
// Reset is synchronous and active high; the frame store itself is not cleared.
// The front keeps taking requests into a short queue while the back waits on rsp_ready.

module nearest_neighbor_image_scaler_unit #(
   parameter int STORE_PIXELS = nns_pkg::STORE_PIXELS_DEF,
   parameter int MAX_DIM      = nns_pkg::MAX_DIM_DEF,
   parameter int PIXEL_BITS   = nns_pkg::PIXEL_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [nns_pkg::PIXEL_OUT_BITS-1:0]  req_load_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [nns_pkg::PIXEL_OUT_BITS-1:0]  rsp_out_value,
   output logic                                rsp_inside_res,
   output logic                                rsp_frame_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nns_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [nns_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int STORE_W = (PIXEL_BITS < nns_pkg::PIXEL_OUT_BITS) ?
                            PIXEL_BITS : nns_pkg::PIXEL_OUT_BITS;
   localparam int AW      = $clog2(STORE_PIXELS);
   localparam int ENT_W   = STORE_W + AW + 2;
   localparam logic [16:0] MAX_DIM_VAL = 17'(MAX_DIM);

   logic [nns_pkg::CFG_DIM_BITS-1:0]   src_width_ff;
   logic [nns_pkg::CFG_DIM_BITS-1:0]   src_height_ff;
   logic [nns_pkg::CFG_DIM_BITS-1:0]   dst_width_ff;
   logic [nns_pkg::CFG_DIM_BITS-1:0]   dst_height_ff;
   logic [nns_pkg::PIXEL_OUT_BITS-1:0] fill_value_ff;

   logic             csr_wr;
   nns_pkg::cfg_type cfg;

   logic             ent_valid;
   logic             ent_ready;
   logic [ENT_W-1:0] ent_data;
   logic             head_valid;
   logic             head_pop;
   logic [ENT_W-1:0] head_data;

   // Configuration port never stalls; user must write registers only while idle, unenforced.
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= nns_pkg::DIM_RESET;
         src_height_ff <= nns_pkg::DIM_RESET;
         dst_width_ff  <= nns_pkg::DIM_RESET;
         dst_height_ff <= nns_pkg::DIM_RESET;
         fill_value_ff <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            nns_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_data[nns_pkg::CFG_DIM_BITS-1:0];
            nns_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_data[nns_pkg::CFG_DIM_BITS-1:0];
            nns_pkg::CSR_DST_WIDTH:  dst_width_ff  <= csr_data[nns_pkg::CFG_DIM_BITS-1:0];
            nns_pkg::CSR_DST_HEIGHT: dst_height_ff <= csr_data[nns_pkg::CFG_DIM_BITS-1:0];
            nns_pkg::CSR_FILL_VALUE: fill_value_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Dimensions are clamped once here, so both halves see the same effective sizes.
   always_comb begin
      cfg.src_width  = nns_pkg::clamp_dim(src_width_ff, MAX_DIM_VAL);
      cfg.src_height = nns_pkg::clamp_dim(src_height_ff, MAX_DIM_VAL);
      cfg.dst_width  = nns_pkg::clamp_dim(dst_width_ff, MAX_DIM_VAL);
      cfg.dst_height = nns_pkg::clamp_dim(dst_height_ff, MAX_DIM_VAL);
      cfg.fill_value = fill_value_ff;
   end

   // The front stamps each load request with its store address, so the back
   // never needs to know the load position.
   nns_front #(
      .STORE_PIXELS(STORE_PIXELS),
      .MAX_DIM     (MAX_DIM),
      .PIXEL_BITS  (PIXEL_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_load_value(req_load_value),
      .ent_valid     (ent_valid),
      .ent_ready     (ent_ready),
      .ent_data      (ent_data)
   );

   // Requests keep their order through the queue, so an emit always sees every earlier load.
   nns_fifo #(
      .WIDTH(ENT_W),
      .DEPTH(nns_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(ent_valid),
      .push_ready(ent_ready),
      .push_data (ent_data),
      .pop_valid (head_valid),
      .pop_ready (head_pop),
      .pop_data  (head_data)
   );

   // The back owns the frame store and the destination position.
   nns_back #(
      .STORE_PIXELS(STORE_PIXELS),
      .MAX_DIM     (MAX_DIM),
      .PIXEL_BITS  (PIXEL_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cfg_wr        (csr_wr),
      .head_valid    (head_valid),
      .head_pop      (head_pop),
      .head_data     (head_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_value (rsp_out_value),
      .rsp_inside_res(rsp_inside_res),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
